// ===== hw/rtl/led_flash_blink_controller_assert.svh =====
`ifndef LED_FLASH_BLINK_CONTROLLER_ASSERT_SVH
`define LED_FLASH_BLINK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define LFBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define LFBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lfbc_pkg.sv =====
package lfbc_pkg;

	localparam int DATA_W = 16;
	localparam int RECIP_W = DATA_W + 1;
	localparam int MS_PER_TICK_DEFAULT = 10;

	typedef enum logic [2:0] {
		ACT_TICK      = 3'd0,
		ACT_ENABLE    = 3'd1,
		ACT_ON        = 3'd2,
		ACT_OFF       = 3'd3,
		ACT_FLASH     = 3'd4,
		ACT_BLINK_ON  = 3'd5,
		ACT_BLINK_OFF = 3'd6
	} action_t;

	localparam logic [DATA_W-1:0] HOLD_MAX = {DATA_W{1'b1}};

endpackage

// ===== hw/rtl/lfbc_tick_div.sv =====
module lfbc_tick_div
	import lfbc_pkg::*;
#(
	parameter int MS_PER_TICK = MS_PER_TICK_DEFAULT
) (
	input  logic [DATA_W-1:0] ms,
	output logic [DATA_W-1:0] ticks
);

	// Floor division by a constant: multiply by ceil(2^SHIFT / MS_PER_TICK) and shift.
	// With SHIFT = DATA_W + ceil(log2(MS_PER_TICK)) the quotient is exact for every input.
	localparam int SHIFT = DATA_W + $clog2(MS_PER_TICK);
	localparam longint unsigned POW = longint'(1) << SHIFT;
	localparam longint unsigned RECIP = (POW + MS_PER_TICK - 1) / MS_PER_TICK;
	localparam int PROD_W = DATA_W + RECIP_W;

	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  shifted;

	assign recip   = RECIP[RECIP_W-1:0];
	assign prod    = PROD_W'(ms) * PROD_W'(recip);
	assign shifted = prod >> SHIFT;
	assign ticks   = shifted[DATA_W-1:0];

endmodule

// ===== hw/rtl/led_flash_blink_controller.sv =====
// A result is valid in the cycle after its command or tick transaction is accepted.
// One transaction per cycle while out_ready is high; the whole state update is one registered pass.
// Series durations are converted to ticks by a constant reciprocal multiply on entry.
// Reset (arst_n low, asynchronous): LED off, output enabled, no hold, no series,
// countdown disarmed, active_high set to 1, no result pending.
module led_flash_blink_controller
	import lfbc_pkg::*;
#(
	parameter int MS_PER_TICK = MS_PER_TICK_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        action,
	input  logic [DATA_W-1:0] value_a,
	input  logic [DATA_W-1:0] value_b,
	input  logic [DATA_W-1:0] value_c,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              pin_level,
	output logic              led_lit,
	output logic              enabled_now,
	output logic              flash_running,
	output logic              blink_running,
	output logic [DATA_W-1:0] hold_depth,
	output logic              timer_running
);

	logic              active_high_q;
	logic              out_valid_q;
	logic              lit_q, enable_q, flash_on_q, blink_on_q, armed_q;
	logic [DATA_W-1:0] hold_q, left_q;
	logic [DATA_W-1:0] flash_len_q, flash_gap_q, flash_reps_q, flash_done_q;
	logic [DATA_W-1:0] blink_len_q, blink_gap_q, blink_reps_q, blink_done_q;

	logic              n_lit, n_enable, n_flash_on, n_blink_on, n_armed;
	logic [DATA_W-1:0] n_hold, n_left;
	logic [DATA_W-1:0] n_flash_len, n_flash_gap, n_flash_reps, n_flash_done;
	logic [DATA_W-1:0] n_blink_len, n_blink_gap, n_blink_reps, n_blink_done;
	logic              do_timeout;
	logic [DATA_W-1:0] flash_next, blink_next;
	logic [DATA_W-1:0] ticks_b, ticks_c;
	logic              in_fire;

	lfbc_tick_div #(.MS_PER_TICK(MS_PER_TICK)) u_div_b (.ms(value_b), .ticks(ticks_b));
	lfbc_tick_div #(.MS_PER_TICK(MS_PER_TICK)) u_div_c (.ms(value_c), .ticks(ticks_c));

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	assign flash_next = flash_done_q + DATA_W'(1);
	assign blink_next = blink_done_q + DATA_W'(1);

	// Durations are kept in ticks, so a countdown reload is a plain copy.
	always_comb begin
		n_lit        = lit_q;
		n_enable     = enable_q;
		n_flash_on   = flash_on_q;
		n_blink_on   = blink_on_q;
		n_armed      = armed_q;
		n_hold       = hold_q;
		n_left       = left_q;
		n_flash_len  = flash_len_q;
		n_flash_gap  = flash_gap_q;
		n_flash_reps = flash_reps_q;
		n_flash_done = flash_done_q;
		n_blink_len  = blink_len_q;
		n_blink_gap  = blink_gap_q;
		n_blink_reps = blink_reps_q;
		n_blink_done = blink_done_q;
		do_timeout   = 1'b0;

		case (action)
			ACT_TICK: begin
				if (armed_q) begin
					if (left_q != '0) begin
						n_left = left_q - DATA_W'(1);
					end
					do_timeout = (left_q == '0) || (left_q == DATA_W'(1));
				end
			end
			ACT_ENABLE: begin
				n_enable = |value_a;
			end
			ACT_ON: begin
				if ((|value_a) && (hold_q != HOLD_MAX)) begin
					n_hold = hold_q + DATA_W'(1);
				end
				n_armed = 1'b0;
				n_left  = '0;
				n_lit   = 1'b1;
			end
			ACT_OFF: begin
				if ((|value_a) && (hold_q != '0)) begin
					n_hold = hold_q - DATA_W'(1);
				end
				if (n_hold == '0) begin
					if (flash_on_q) begin
						n_armed = 1'b1;
						n_left  = flash_gap_q;
					end else if (blink_on_q) begin
						n_armed      = 1'b1;
						n_left       = blink_gap_q;
						n_blink_done = '0;
					end else begin
						n_armed = 1'b0;
						n_left  = '0;
					end
					n_lit = 1'b0;
				end
			end
			ACT_FLASH: begin
				n_flash_on   = 1'b1;
				n_flash_reps = value_a;
				n_flash_len  = ticks_b;
				n_flash_gap  = ticks_c;
				n_flash_done = '0;
				if (hold_q == '0) begin
					n_armed = 1'b1;
					n_left  = ticks_b;
					n_lit   = 1'b1;
				end
			end
			ACT_BLINK_ON: begin
				n_blink_on   = 1'b1;
				n_blink_reps = value_a;
				n_blink_len  = ticks_b;
				n_blink_gap  = ticks_c;
				n_blink_done = '0;
				if ((hold_q == '0) && !flash_on_q) begin
					n_armed = 1'b1;
					n_left  = ticks_b;
					n_lit   = 1'b1;
				end
			end
			ACT_BLINK_OFF: begin
				if (blink_on_q) begin
					n_blink_on = 1'b0;
					if (hold_q == '0) begin
						n_armed = 1'b0;
						n_left  = '0;
						n_lit   = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase

		// Expiry of the countdown steps whichever series is active, flash first, and disarms it if none is.
		if (do_timeout) begin
			if (flash_on_q) begin
				if (lit_q) begin
					if (flash_next >= flash_reps_q) begin
						n_flash_done = '0;
						n_flash_on   = 1'b0;
						if (hold_q == '0) begin
							if (blink_on_q) begin
								n_armed      = 1'b1;
								n_left       = blink_gap_q;
								n_blink_done = '0;
							end else begin
								n_armed = 1'b0;
								n_left  = '0;
							end
							n_lit = 1'b0;
						end else begin
							n_armed = 1'b0;
							n_left  = '0;
						end
					end else begin
						n_flash_done = flash_next;
						n_armed      = 1'b1;
						n_left       = flash_gap_q;
						n_lit        = 1'b0;
					end
				end else begin
					n_armed = 1'b1;
					n_left  = flash_len_q;
					n_lit   = 1'b1;
				end
			end else if (blink_on_q) begin
				if (lit_q) begin
					n_armed = 1'b1;
					if (blink_next >= blink_reps_q) begin
						n_blink_done = '0;
						n_left       = blink_gap_q;
					end else begin
						n_blink_done = blink_next;
						n_left       = blink_len_q;
					end
					n_lit = 1'b0;
				end else begin
					n_armed = 1'b1;
					n_left  = blink_len_q;
					n_lit   = 1'b1;
				end
			end else begin
				n_armed = 1'b0;
				n_left  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b1;
		end else if (cfg_valid) begin
			active_high_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q        <= 1'b0;
			enable_q     <= 1'b1;
			flash_on_q   <= 1'b0;
			blink_on_q   <= 1'b0;
			armed_q      <= 1'b0;
			hold_q       <= '0;
			left_q       <= '0;
			flash_len_q  <= '0;
			flash_gap_q  <= '0;
			flash_reps_q <= '0;
			flash_done_q <= '0;
			blink_len_q  <= '0;
			blink_gap_q  <= '0;
			blink_reps_q <= '0;
			blink_done_q <= '0;
		end else if (in_fire) begin
			lit_q        <= n_lit;
			enable_q     <= n_enable;
			flash_on_q   <= n_flash_on;
			blink_on_q   <= n_blink_on;
			armed_q      <= n_armed;
			hold_q       <= n_hold;
			left_q       <= n_left;
			flash_len_q  <= n_flash_len;
			flash_gap_q  <= n_flash_gap;
			flash_reps_q <= n_flash_reps;
			flash_done_q <= n_flash_done;
			blink_len_q  <= n_blink_len;
			blink_gap_q  <= n_blink_gap;
			blink_reps_q <= n_blink_reps;
			blink_done_q <= n_blink_done;
		end
	end

	// The state registers only move when a transaction is accepted, which frees the
	// pending result in the same edge, so they double as the result register.
	assign out_valid     = out_valid_q;
	assign pin_level     = ((enable_q && lit_q) == active_high_q);
	assign led_lit       = lit_q;
	assign enabled_now   = enable_q;
	assign flash_running = flash_on_q;
	assign blink_running = blink_on_q;
	assign hold_depth    = hold_q;
	assign timer_running = armed_q;

endmodule

// ===== hw/rtl/lfbc_checker.sv =====
`include "led_flash_blink_controller_assert.svh"

module lfbc_checker
	import lfbc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [2:0]        action,
	input logic              out_valid,
	input logic              out_ready,
	input logic              led_lit,
	input logic              flash_running,
	input logic [DATA_W-1:0] hold_depth,
	input logic              timer_running
);

	// An empty or draining output stage must never block the input side.
	`LFBC_ASSERT_NOW(a_ready_when_free, (!out_valid || out_ready), in_ready, "input stalled while output stage free")

	`LFBC_ASSERT_NEXT(a_result_follows, (in_valid && in_ready), out_valid, "accepted transaction gave no result")

	`LFBC_ASSERT_NEXT(a_result_holds, (out_valid && !out_ready), (out_valid && $stable(hold_depth) && $stable(led_lit)), "pending result changed while stalled")

	// A steady-on command lights the LED and stops the countdown.
	`LFBC_ASSERT_NEXT(a_on_lights, (in_valid && in_ready && action == ACT_ON), (led_lit && !timer_running), "on command did not light the LED")

	// A new flash series always runs.
	`LFBC_ASSERT_NEXT(a_flash_starts, (in_valid && in_ready && action == ACT_FLASH), flash_running, "flash command did not start a series")

endmodule

bind led_flash_blink_controller lfbc_checker u_lfbc_checker (.*);
